@@ sv/ffa_pkg.sv @@
package ffa_pkg;

    localparam int HEAP_BYTES   = 65536;
    localparam int HEADER_BYTES = 16;
    localparam int GRAN_BYTES   = 8;
    localparam int GRAN_W       = $clog2(GRAN_BYTES);
    localparam int ENTRIES      = HEAP_BYTES / GRAN_BYTES;
    localparam int IDX_W        = $clog2(ENTRIES);
    localparam int OFF_W        = 16;
    localparam int SIZE_W       = 17;
    localparam int REQ_W        = 17;
    localparam int NEED_W       = 18;

    typedef struct packed {
        logic              valid;
        logic              free;
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  next;
    } t_hdr;

    localparam int HDR_W = $bits(t_hdr);

    typedef struct packed {
        logic             mode;
        logic [REQ_W-1:0] request_bytes;
        logic [OFF_W-1:0] payload_offset;
    } t_in;

    typedef struct packed {
        logic [OFF_W-1:0] granted_offset;
        logic             granted;
    } t_out;

    localparam logic MODE_ALLOC = 1'b0;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_A_RD, ST_A_CHK, ST_A_SPLIT, ST_A_WB,
        ST_R_RD, ST_R_CHK, ST_R_NCHK, ST_R_WB, ST_P_RD, ST_P_CHK,
        ST_P_WB, ST_P_WB2, ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        CMD_NOP, CMD_CLEAR, CMD_LOAD, CMD_RD_AT, CMD_A_CHK, CMD_A_SPLIT,
        CMD_A_WB, CMD_R_CHK, CMD_R_NCHK, CMD_R_WB, CMD_P_RD, CMD_P_CHK,
        CMD_P_WB, CMD_P_WB2
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic zero_req;
        logic bad_rel;
        logic fit;
        logic split;
        logic chain_end;
        logic hdr_valid;
        logic hdr_free;
        logic at_zero;
        logic pred_hit;
    } t_sts;

    function automatic logic [IDX_W-1:0] idx_of(input logic [OFF_W-1:0] off);
        return off[OFF_W-1:GRAN_W];
    endfunction

endpackage

@@ sv/ffa_ram.sv @@
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/ffa_datapath.sv @@
module ffa_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ffa_pkg::t_cmd i_cmd,
    input  ffa_pkg::t_in  i_item,
    output ffa_pkg::t_sts o_sts,
    output ffa_pkg::t_out o_result
);
    import ffa_pkg::*;

    localparam logic [OFF_W-1:0]  HDR_OFF  = OFF_W'(HEADER_BYTES);
    localparam logic [SIZE_W-1:0] HDR_SIZE = SIZE_W'(HEADER_BYTES);
    localparam t_hdr HDR_INIT = '{valid: 1'b1, free: 1'b1,
        size: SIZE_W'(HEAP_BYTES - HEADER_BYTES), next: '0};

    logic [IDX_W-1:0]  r_clr;
    logic [NEED_W-1:0] r_need;
    logic [OFF_W-1:0]  r_at, r_w;
    logic              r_bad;
    logic [SIZE_W-1:0] r_wsize;
    t_hdr              r_b;
    t_out              r_res;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_addr;
    t_hdr              ram_wdata, rd;
    logic [HDR_W-1:0]  ram_rdata;
    logic [NEED_W-1:0] s_sum;
    logic [OFF_W-1:0]  rel_at;

    ffa_ram #(.WIDTH(HDR_W), .DEPTH(ENTRIES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign rd     = t_hdr'(ram_rdata);
    assign s_sum  = NEED_W'(r_at) + NEED_W'(HEADER_BYTES) + r_need;
    assign rel_at = i_item.payload_offset - HDR_OFF;

    always_comb begin
        o_sts.clr_last  = (r_clr == IDX_W'(ENTRIES - 1));
        o_sts.zero_req  = (r_need == '0);
        o_sts.bad_rel   = r_bad;
        o_sts.fit       = rd.free && (NEED_W'(rd.size) >= r_need);
        // Split only when the leftover can carry a header and a minimum payload.
        o_sts.split     = o_sts.fit
                          && (NEED_W'(rd.size) > r_need + NEED_W'(HEADER_BYTES + GRAN_BYTES))
                          && (s_sum < NEED_W'(HEAP_BYTES));
        o_sts.chain_end = (rd.next == '0);
        o_sts.hdr_valid = rd.valid;
        o_sts.hdr_free  = rd.free;
        o_sts.at_zero   = (r_at == '0);
        o_sts.pred_hit  = (rd.next == r_at);
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = idx_of(r_at);
        ram_wdata = r_b;
        unique case (i_cmd) inside
            CMD_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr;
                ram_wdata = (r_clr == '0) ? HDR_INIT : '0;
            end
            CMD_A_CHK, CMD_R_CHK, CMD_P_CHK: begin
                ram_addr = idx_of(rd.next);
            end
            CMD_A_SPLIT: begin
                ram_we    = 1'b1;
                ram_addr  = idx_of(s_sum[OFF_W-1:0]);
                ram_wdata = '{valid: 1'b1, free: 1'b1,
                              size: r_b.size - r_need[SIZE_W-1:0] - HDR_SIZE,
                              next: r_b.next};
            end
            CMD_A_WB: begin
                ram_we         = 1'b1;
                ram_wdata.free = 1'b0;
            end
            CMD_R_NCHK: begin
                ram_we          = rd.free;
                ram_addr        = idx_of(r_b.next);
                ram_wdata       = rd;
                ram_wdata.valid = 1'b0;
            end
            CMD_R_WB: begin
                ram_we = 1'b1;
            end
            CMD_P_RD: begin
                ram_addr = '0;
            end
            CMD_P_WB: begin
                ram_we    = 1'b1;
                ram_addr  = idx_of(r_w);
                ram_wdata = '{valid: 1'b1, free: 1'b1,
                              size: r_wsize + r_b.size + HDR_SIZE,
                              next: r_b.next};
            end
            CMD_P_WB2: begin
                ram_we          = 1'b1;
                ram_wdata.valid = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd == CMD_CLEAR) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: begin
                r_need <= (NEED_W'(i_item.request_bytes) + NEED_W'(GRAN_BYTES - 1))
                          & ~NEED_W'(GRAN_BYTES - 1);
                r_at   <= (i_item.mode == MODE_ALLOC) ? '0 : rel_at;
                r_bad  <= (i_item.payload_offset < HDR_OFF) || (rel_at[GRAN_W-1:0] != '0);
                r_res  <= '0;
            end
            CMD_A_CHK: begin
                r_b <= rd;
                if (!o_sts.fit) begin
                    r_at <= rd.next;
                end
            end
            CMD_A_SPLIT: begin
                r_b.size <= r_need[SIZE_W-1:0];
                r_b.next <= s_sum[OFF_W-1:0];
            end
            CMD_A_WB: begin
                r_res <= '{granted_offset: r_at + HDR_OFF, granted: 1'b1};
            end
            CMD_R_CHK: begin
                r_b <= '{valid: rd.valid, free: 1'b1, size: rd.size, next: rd.next};
            end
            CMD_R_NCHK: begin
                if (rd.free) begin
                    r_b.size <= r_b.size + rd.size + HDR_SIZE;
                    r_b.next <= rd.next;
                end
            end
            CMD_P_RD: begin
                r_w <= '0;
            end
            CMD_P_CHK: begin
                r_wsize <= rd.size;
                if (!o_sts.pred_hit) begin
                    r_w <= rd.next;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result = r_res;
endmodule

@@ sv/ffa_ctrl.sv @@
module ffa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic          i_mode,
    input  ffa_pkg::t_sts i_sts,
    output ffa_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_valid
);
    import ffa_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:   if (i_sts.clr_last) n_state = ST_IDLE;
            ST_IDLE:    if (i_go) n_state = (i_mode == MODE_ALLOC) ? ST_A_RD : ST_R_RD;
            ST_A_RD:    n_state = i_sts.zero_req ? ST_DONE : ST_A_CHK;
            ST_A_CHK: begin
                if (i_sts.split) n_state = ST_A_SPLIT;
                else if (i_sts.fit) n_state = ST_A_WB;
                else if (i_sts.chain_end) n_state = ST_DONE;
            end
            ST_A_SPLIT: n_state = ST_A_WB;
            ST_A_WB:    n_state = ST_DONE;
            ST_R_RD:    n_state = i_sts.bad_rel ? ST_DONE : ST_R_CHK;
            ST_R_CHK: begin
                if (!i_sts.hdr_valid) n_state = ST_DONE;
                else if (i_sts.chain_end) n_state = ST_R_WB;
                else n_state = ST_R_NCHK;
            end
            ST_R_NCHK:  n_state = ST_R_WB;
            ST_R_WB:    n_state = i_sts.at_zero ? ST_DONE : ST_P_RD;
            ST_P_RD:    n_state = ST_P_CHK;
            ST_P_CHK: begin
                if (i_sts.pred_hit) n_state = i_sts.hdr_free ? ST_P_WB : ST_DONE;
                else if (i_sts.chain_end) n_state = ST_DONE;
            end
            ST_P_WB:    n_state = ST_P_WB2;
            ST_P_WB2:   n_state = ST_DONE;
            ST_DONE:    n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_busy  = (r_state != ST_IDLE);
        o_valid = (r_state == ST_DONE);
        unique case (r_state)
            ST_CLEAR:   o_cmd = CMD_CLEAR;
            ST_IDLE:    o_cmd = i_go ? CMD_LOAD : CMD_NOP;
            ST_A_RD:    o_cmd = CMD_RD_AT;
            ST_A_CHK:   o_cmd = CMD_A_CHK;
            ST_A_SPLIT: o_cmd = CMD_A_SPLIT;
            ST_A_WB:    o_cmd = CMD_A_WB;
            ST_R_RD:    o_cmd = CMD_RD_AT;
            ST_R_CHK:   o_cmd = CMD_R_CHK;
            ST_R_NCHK:  o_cmd = CMD_R_NCHK;
            ST_R_WB:    o_cmd = CMD_R_WB;
            ST_P_RD:    o_cmd = CMD_P_RD;
            ST_P_CHK:   o_cmd = CMD_P_CHK;
            ST_P_WB:    o_cmd = CMD_P_WB;
            ST_P_WB2:   o_cmd = CMD_P_WB2;
            default:    o_cmd = CMD_NOP;
        endcase
    end
endmodule

@@ sv/first_fit_heap_allocator_top.sv @@
// First-fit heap allocator over a 64 KiB heap with 16-byte block headers kept in an
// 8192-entry header RAM (one entry per 8-byte granule). After reset the block runs a
// clearing pass with busy high before it takes its first word. A word is taken when
// start is high and busy is low; its result appears for one cycle with o_valid and
// cannot be held off. An allocate walks the chain from the head, reading one block
// header at a time, and splits the chosen block when the leftover is large enough; a
// zero-size request is answered without a walk. A release checks the block and merges
// a free successor into it, then walks from the head to its predecessor and merges into
// that predecessor when it is free. The header RAM is single-port, read once per cycle.
module first_fit_heap_allocator_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  ffa_pkg::t_in  i_item,
    output logic          busy,
    output logic          o_valid,
    output ffa_pkg::t_out o_result
);
    import ffa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ffa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (start),
        .i_mode  (i_item.mode),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    ffa_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .o_sts    (sts),
        .o_result (o_result)
    );
endmodule

@@ sv/ffa_checker.sv @@
module ffa_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_valid,
    input ffa_pkg::t_out o_result
);
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result word while idle");

    a_granted_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.granted |-> o_result.granted_offset != '0)
        else $error("granted with null offset");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.granted |-> o_result.granted_offset == '0)
        else $error("failed word with nonzero offset");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_valid) else $error("word taken without going busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");
endmodule

bind first_fit_heap_allocator_top ffa_checker u_ffa_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

@@ sim/tb_first_fit_heap_allocator_top.sv @@
`timescale 1ns / 100ps

module tb_first_fit_heap_allocator_top;

    import ffa_pkg::*;

    localparam int N_RANDOM   = 1000;
    localparam int STALL_MAX  = 20000;
    localparam int DRAIN_CYC  = 64;
    localparam logic MODE_RELEASE = 1'b1;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    t_in   i_item;
    logic  busy;
    logic  o_valid;
    t_out  o_result;

    first_fit_heap_allocator_top i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Shadow of the header store, one entry per heap byte offset.
    bit          hv [HEAP_BYTES];
    bit          hf [HEAP_BYTES];
    int unsigned hs [HEAP_BYTES];
    int unsigned hn [HEAP_BYTES];

    t_in  word_q [$];
    t_out grant_q [$];
    int unsigned live_q [$];

    int sent_cnt, taken_cnt, result_cnt, errors;
    int n_alloc, n_grant, n_release;
    bit no_idle;

    function automatic int unsigned heap_alloc(input int unsigned req);
        int unsigned at, need, s;
        at = 0;
        if (req == 0) return 0;
        need = (req + 7) & ~32'd7;
        forever begin
            if (hf[at] && hs[at] >= need) begin
                if (hs[at] > need + HEADER_BYTES + 8) begin
                    s = at + HEADER_BYTES + need;
                    if (s < HEAP_BYTES) begin
                        hv[s] = 1'b1;
                        hf[s] = 1'b1;
                        hs[s] = hs[at] - need - HEADER_BYTES;
                        hn[s] = hn[at];
                        hs[at] = need;
                        hn[at] = s;
                    end
                end
                hf[at] = 1'b0;
                return at + HEADER_BYTES;
            end
            if (hn[at] == 0 || hn[at] >= HEAP_BYTES) return 0;
            at = hn[at];
        end
    endfunction

    function automatic void heap_release(input int unsigned pay);
        int unsigned at, w, nx;
        if (pay < HEADER_BYTES) return;
        at = pay - HEADER_BYTES;
        if (at >= HEAP_BYTES || !hv[at]) return;
        hf[at] = 1'b1;
        nx = hn[at];
        if (nx != 0 && nx < HEAP_BYTES && hf[nx]) begin
            hs[at] = hs[at] + hs[nx] + HEADER_BYTES;
            hn[at] = hn[nx];
            hv[nx] = 1'b0;
        end
        if (at == 0) return;
        w = 0;
        while (hn[w] != at) begin
            w = hn[w];
            if (w == 0 || w >= HEAP_BYTES) return;
        end
        if (hf[w]) begin
            hs[w] = hs[w] + hs[at] + HEADER_BYTES;
            hn[w] = hn[at];
            hv[at] = 1'b0;
        end
    endfunction

    // The word stream is fixed up front, so the grant for each word is worked
    // out as it is queued; the block handles words strictly in order.
    task automatic queue_word(input logic mode, input int unsigned req,
                              input int unsigned pay);
        t_in  w;
        t_out r;
        int unsigned got;
        w.mode = mode;
        w.request_bytes = req[REQ_W-1:0];
        w.payload_offset = pay[OFF_W-1:0];
        got = 0;
        if (mode == MODE_ALLOC) begin
            got = heap_alloc(w.request_bytes);
            n_alloc++;
            if (got != 0) begin
                n_grant++;
                live_q.push_back(got);
            end
        end else begin
            heap_release(w.payload_offset);
            n_release++;
        end
        r.granted_offset = got[OFF_W-1:0];
        r.granted = (got != 0);
        word_q.push_back(w);
        grant_q.push_back(r);
    endtask

    task automatic release_live(input int idx);
        int unsigned p;
        p = live_q[idx];
        live_q.delete(idx);
        queue_word(MODE_RELEASE, $urandom, p);
    endtask

    task automatic build_stimulus();
        int unsigned p, k;
        hv[0] = 1'b1;
        hf[0] = 1'b1;
        hs[0] = HEAP_BYTES - HEADER_BYTES;
        hn[0] = 0;
        queue_word(MODE_ALLOC, 0, 16'hFFFF);
        queue_word(MODE_ALLOC, 17'h1FFFF, 0);
        queue_word(MODE_ALLOC, 65536, 0);
        queue_word(MODE_ALLOC, 1, 0);
        queue_word(MODE_ALLOC, 8, 0);
        queue_word(MODE_ALLOC, 9, 0);
        queue_word(MODE_ALLOC, 40, 0);
        queue_word(MODE_RELEASE, 0, 0);
        queue_word(MODE_RELEASE, 0, 5);
        queue_word(MODE_RELEASE, 0, 16'hFFFF);
        queue_word(MODE_RELEASE, 0, 16'h8010);
        queue_word(MODE_RELEASE, 0, live_q[0] + 8);
        queue_word(MODE_RELEASE, 0, live_q[0] + 3);
        // Free the middle block twice, then its neighbors so both merges occur.
        p = live_q[1];
        queue_word(MODE_RELEASE, 0, p);
        queue_word(MODE_RELEASE, 0, p);
        while (live_q.size() > 0) release_live(live_q.size() - 1);
        // Exact fit of the whole heap, then a block with surplus of exactly
        // one header plus one granule, which must not be split.
        queue_word(MODE_ALLOC, HEAP_BYTES - HEADER_BYTES, 0);
        release_live(0);
        queue_word(MODE_ALLOC, 64, 0);
        queue_word(MODE_ALLOC, 64, 0);
        release_live(0);
        queue_word(MODE_ALLOC, 40, 0);
        queue_word(MODE_ALLOC, 1, 0);
        while (live_q.size() > 0) release_live(0);

        for (int i = 0; i < N_RANDOM; i++) begin
            k = $urandom_range(99);
            if (k < 55 || live_q.size() == 0) begin
                k = $urandom_range(99);
                if (k < 3) queue_word(MODE_ALLOC, 0, $urandom);
                else if (k < 8) queue_word(MODE_ALLOC, $urandom_range(17'h1FFFF), $urandom);
                else if (k < 15) queue_word(MODE_ALLOC, $urandom_range(4096), $urandom);
                else queue_word(MODE_ALLOC, $urandom_range(1, 200), $urandom);
            end else if (k < 90) begin
                release_live($urandom_range(live_q.size() - 1));
            end else if (k < 93) begin
                queue_word(MODE_RELEASE, $urandom, 0);
            end else begin
                queue_word(MODE_RELEASE, $urandom, $urandom);
            end
        end
    endtask

    // Driver: a new word goes out once the previous one has been taken.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!start || taken_cnt == sent_cnt) begin
                no_idle = (sent_cnt > 300 && sent_cnt < 550);
                if (word_q.size() > 0 && (no_idle || $urandom_range(99) >= 26)) begin
                    i_item <= word_q.pop_front();
                    start <= 1'b1;
                    sent_cnt <= sent_cnt + 1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    int stall_cnt;

    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) begin
                stall_cnt <= 0;
            end else begin
                stall_cnt <= stall_cnt + 1;
            end
            if (start && !busy) begin
                taken_cnt <= taken_cnt + 1;
            end
            if (o_valid) begin
                result_cnt <= result_cnt + 1;
                if (grant_q.size() == 0) begin
                    $display("%0t: unexpected word: actual offset %h granted %b",
                             $realtime, o_result.granted_offset, o_result.granted);
                    errors++;
                end else begin
                    exp_r = grant_q.pop_front();
                    if (o_result.granted_offset !== exp_r.granted_offset) begin
                        $display("%0t: granted_offset mismatch: expected %h actual %h",
                                 $realtime, exp_r.granted_offset, o_result.granted_offset);
                        errors++;
                    end
                    if (o_result.granted !== exp_r.granted) begin
                        $display("%0t: granted mismatch: expected %b actual %b",
                                 $realtime, exp_r.granted, o_result.granted);
                        errors++;
                    end
                end
            end
            if (stall_cnt > STALL_MAX + HEAP_BYTES / GRAN_BYTES) begin
                $display("%0t: no progress, %0d words still awaited", $realtime,
                         grant_q.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        sent_cnt = 0;
        taken_cnt = 0;
        result_cnt = 0;
        errors = 0;
        stall_cnt = 0;
        n_alloc = 0;
        n_grant = 0;
        n_release = 0;
        build_stimulus();
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        while (word_q.size() != 0 || taken_cnt != sent_cnt || grant_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYC) @(posedge i_clk);
        $display("Ran %0d allocates (%0d granted) and %0d releases, %0d results checked.",
                 n_alloc, n_grant, n_release, result_cnt);
        $display("Stimulus covered zero size, no fit, exact fit, split edge and bad frees.");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
